### hw/rtl/mec_pkg.sv
// ----------------------------------------------------------------------------
// Multibrot escape colouring package
// Shared item types, command and status structs, and fixed constants.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int COORD_W     = 32;
  localparam int COUNT_W     = 16;
  localparam int POWER_W     = 4;
  localparam int COLOR_W     = 8;
  localparam int PROD_W      = 64;
  localparam int DIVIDEND_W  = 24;
  localparam int QUOT_W      = 8;
  localparam int SECTOR_W    = 3;
  localparam int CFG_INDEX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ITER_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER      = 1'd1;

  localparam logic [COUNT_W-1:0] ITER_LIMIT_RESET = 16'd80;
  localparam logic [POWER_W-1:0] POWER_RESET      = 4'd2;

  // Product selects for the shared multiplier (w operand, z operand).
  localparam logic [1:0] MUL_RR = 2'd0;
  localparam logic [1:0] MUL_II = 2'd1;
  localparam logic [1:0] MUL_RI = 2'd2;
  localparam logic [1:0] MUL_IR = 2'd3;

  // Accumulator operations.
  localparam logic [2:0] ACC_NONE    = 3'd0;
  localparam logic [2:0] ACC_RE_LOAD = 3'd1;
  localparam logic [2:0] ACC_RE_SUB  = 3'd2;
  localparam logic [2:0] ACC_IM_LOAD = 3'd3;
  localparam logic [2:0] ACC_IM_ADD  = 3'd4;

  // Divisions done for the colour.
  localparam logic [1:0] DIV_SECTOR = 2'd0;
  localparam logic [1:0] DIV_RISE   = 2'd1;
  localparam logic [1:0] DIV_FALL   = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iter_count;
    logic               escaped;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } out_item_t;

  typedef struct packed {
    logic       load_c;
    logic       start_round;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic [2:0] acc_op;
    logic       w_load;
    logic       z_update;
    logic       div_start;
    logic       div_store;
    logic [1:0] div_sel;
    logic       res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
    logic below_limit;
    logic div_done;
  } dp_status_t;

endpackage

### hw/rtl/mec_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Produces one quotient bit per cycle; the quotient must fit in QUOT_W bits.
// ----------------------------------------------------------------------------
module mec_div import mec_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [COUNT_W-1:0]    divisor,
  output logic                  done,
  output logic [QUOT_W-1:0]     quot,
  output logic [COUNT_W-1:0]    remainder
);

  localparam int STEP_W = $clog2(QUOT_W);

  logic [DIVIDEND_W-1:0] part;
  logic [QUOT_W-1:0]     q;
  logic [STEP_W-1:0]     step;
  logic                  running;
  logic                  done_r;
  logic [DIVIDEND_W-1:0] shifted;
  logic [DIVIDEND_W:0]   trial;

  assign shifted = {{(DIVIDEND_W-COUNT_W){1'b0}}, divisor} << step;
  assign trial   = {1'b0, part} - {1'b0, shifted};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && step == '0) begin
        running <= 1'b0;
        done_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part <= dividend;
      q    <= '0;
      step <= STEP_W'(QUOT_W - 1);
    end else if (running) begin
      if (!trial[DIVIDEND_W]) begin
        part <= trial[DIVIDEND_W-1:0];
      end
      q    <= {q[QUOT_W-2:0], ~trial[DIVIDEND_W]};
      step <= step - STEP_W'(1);
    end
  end

  assign done      = done_r;
  assign quot      = q;
  assign remainder = part[COUNT_W-1:0];

endmodule

### hw/rtl/mec_dpath.sv
// ----------------------------------------------------------------------------
// Escape-time datapath
// Holds c, z and w, the shared multiplier and accumulators, the colour
// divider and the result register.
// ----------------------------------------------------------------------------
module mec_dpath import mec_pkg::*; #(
  parameter int COORD_FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  in_item_t           in_item,
  input  logic [COUNT_W-1:0] iteration_limit,
  output out_item_t          result
);

  localparam logic [PROD_W-1:0] TWO_BOUND = PROD_W'(2) << COORD_FRAC_BITS;
  localparam logic signed [PROD_W-1:0] SAT_MAX =
    {{(PROD_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_MIN =
    {{(PROD_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
  localparam logic [COLOR_W-1:0] FULL = {COLOR_W{1'b1}};

  localparam logic [SECTOR_W-1:0] SEC_RED_YELLOW    = 3'd0;
  localparam logic [SECTOR_W-1:0] SEC_YELLOW_GREEN  = 3'd1;
  localparam logic [SECTOR_W-1:0] SEC_GREEN_CYAN    = 3'd2;
  localparam logic [SECTOR_W-1:0] SEC_CYAN_BLUE     = 3'd3;
  localparam logic [SECTOR_W-1:0] SEC_BLUE_MAGENTA  = 3'd4;

  function automatic logic signed [COORD_W-1:0] sat_prod(input logic signed [PROD_W-1:0] x);
    if (x > SAT_MAX) begin
      return SAT_MAX[COORD_W-1:0];
    end else if (x < SAT_MIN) begin
      return SAT_MIN[COORD_W-1:0];
    end
    return x[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_add(input logic signed [COORD_W-1:0] a,
                                                         input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? SAT_MIN[COORD_W-1:0] : SAT_MAX[COORD_W-1:0];
    end
    return s[COORD_W-1:0];
  endfunction

  logic signed [COORD_W-1:0] c_re, c_im, z_re, z_im, w_re, w_im;
  logic signed [COORD_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0]  prod, prod_shift, acc_re, acc_im;
  logic [COUNT_W-1:0]        n;
  logic [COORD_W:0]          abs_re, abs_im;
  logic                      out_re, out_im, below_limit;

  logic [SECTOR_W-1:0]   sector;
  logic [COUNT_W-1:0]    rem;
  logic [COLOR_W-1:0]    rise, fall;
  logic [DIVIDEND_W-1:0] dividend;
  logic [COUNT_W-1:0]    fall_num;
  logic [COUNT_W+2:0]    six_n;
  logic                  div_done;
  logic [QUOT_W-1:0]     div_quot;
  logic [COUNT_W-1:0]    div_rem;
  logic [COLOR_W-1:0]    red, green, blue;

  // Escape test on z: either magnitude at or beyond two.
  assign abs_re = z_re[COORD_W-1] ? ({(COORD_W+1){1'b0}} - {z_re[COORD_W-1], z_re})
                                  : {z_re[COORD_W-1], z_re};
  assign abs_im = z_im[COORD_W-1] ? ({(COORD_W+1){1'b0}} - {z_im[COORD_W-1], z_im})
                                  : {z_im[COORD_W-1], z_im};
  assign out_re = {{(PROD_W-COORD_W-1){1'b0}}, abs_re} >= TWO_BOUND;
  assign out_im = {{(PROD_W-COORD_W-1){1'b0}}, abs_im} >= TWO_BOUND;
  assign below_limit = n < iteration_limit;

  assign status.stop        = !below_limit || out_re || out_im;
  assign status.below_limit = below_limit;
  assign status.div_done    = div_done;

  // Operand selection for the shared multiplier.
  assign op_a = (cmd.mul_sel == MUL_II || cmd.mul_sel == MUL_IR) ? w_im : w_re;
  assign op_b = (cmd.mul_sel == MUL_RR || cmd.mul_sel == MUL_IR) ? z_re : z_im;
  assign prod_shift = prod >>> COORD_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end
    case (cmd.acc_op)
      ACC_RE_LOAD: acc_re <= prod_shift;
      ACC_RE_SUB:  acc_re <= acc_re - prod_shift;
      ACC_IM_LOAD: acc_im <= prod_shift;
      ACC_IM_ADD:  acc_im <= acc_im + prod_shift;
      default: ;
    endcase
    if (cmd.load_c) begin
      c_re <= in_item.c_real;
      c_im <= in_item.c_imag;
      z_re <= '0;
      z_im <= '0;
      n    <= '0;
    end
    if (cmd.start_round) begin
      w_re <= z_re;
      w_im <= z_im;
    end
    if (cmd.w_load) begin
      w_re <= sat_prod(acc_re);
      w_im <= sat_prod(acc_im);
    end
    if (cmd.z_update) begin
      z_re <= sat_add(w_re, c_re);
      z_im <= sat_add(w_im, c_im);
      n    <= n + COUNT_W'(1);
    end
  end

  // Colour divisions: sector = 6n / limit, then the rising and falling ramps.
  assign six_n    = {1'b0, n, 2'b00} + {2'b00, n, 1'b0};
  assign fall_num = iteration_limit - rem;

  always_comb begin
    case (cmd.div_sel)
      DIV_RISE: dividend = {rem, 8'd0} - {8'd0, rem};
      DIV_FALL: dividend = {fall_num, 8'd0} - {8'd0, fall_num};
      default:  dividend = {{(DIVIDEND_W-COUNT_W-3){1'b0}}, six_n};
    endcase
  end

  mec_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dividend),
    .divisor   (iteration_limit),
    .done      (div_done),
    .quot      (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_sel)
        DIV_RISE: rise <= div_quot;
        DIV_FALL: fall <= div_quot;
        default: begin
          sector <= div_quot[SECTOR_W-1:0];
          rem    <= div_rem;
        end
      endcase
    end
  end

  always_comb begin
    unique case (sector)
      SEC_RED_YELLOW:   begin red = FULL; green = rise; blue = '0;   end
      SEC_YELLOW_GREEN: begin red = fall; green = FULL; blue = '0;   end
      SEC_GREEN_CYAN:   begin red = '0;   green = FULL; blue = rise; end
      SEC_CYAN_BLUE:    begin red = '0;   green = fall; blue = FULL; end
      SEC_BLUE_MAGENTA: begin red = rise; green = '0;   blue = FULL; end
      default:          begin red = FULL; green = '0;   blue = fall; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result.iter_count <= n;
      result.escaped    <= below_limit;
      result.red        <= below_limit ? red : '0;
      result.green      <= below_limit ? green : '0;
      result.blue       <= below_limit ? blue : '0;
    end
  end

endmodule

### hw/rtl/mec_ctrl.sv
// ----------------------------------------------------------------------------
// Escape-time controller
// Sequences the iteration rounds, the colour divisions and the result handoff.
// ----------------------------------------------------------------------------
module mec_ctrl import mec_pkg::*; #(
  parameter int MAX_POWER = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic [POWER_W-1:0] power,
  input  dp_status_t         status,
  output dp_cmd_t            cmd
);

  localparam int CW = $clog2(MAX_POWER);
  localparam logic [4:0] POWER_MIN = 5'd2;
  localparam logic [4:0] POWER_MAX = 5'(MAX_POWER);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_MUL0   = 4'd2;
  localparam logic [3:0] S_MUL1   = 4'd3;
  localparam logic [3:0] S_MUL2   = 4'd4;
  localparam logic [3:0] S_MUL3   = 4'd5;
  localparam logic [3:0] S_MUL4   = 4'd6;
  localparam logic [3:0] S_WUPD   = 4'd7;
  localparam logic [3:0] S_ZUPD   = 4'd8;
  localparam logic [3:0] S_SEC    = 4'd9;
  localparam logic [3:0] S_SEC_W  = 4'd10;
  localparam logic [3:0] S_RISE   = 4'd11;
  localparam logic [3:0] S_RISE_W = 4'd12;
  localparam logic [3:0] S_FALL   = 4'd13;
  localparam logic [3:0] S_FALL_W = 4'd14;
  localparam logic [3:0] S_RES    = 4'd15;

  logic [3:0]    state, state_next;
  logic [CW-1:0] mul_left, mul_left_next;
  logic          out_valid_next;
  logic [4:0]    pw, k;
  logic [CW-1:0] mul_count;

  assign pw        = {1'b0, power};
  assign k         = (pw < POWER_MIN) ? POWER_MIN : ((pw > POWER_MAX) ? POWER_MAX : pw);
  assign mul_count = CW'(k - 5'd1);
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    mul_left_next  = mul_left;
    cmd            = '0;
    cmd.acc_op     = ACC_NONE;
    cmd.mul_sel    = MUL_RR;
    cmd.div_sel    = DIV_SECTOR;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_c = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.stop) begin
          state_next = status.below_limit ? S_SEC : S_RES;
        end else begin
          cmd.start_round = 1'b1;
          mul_left_next   = mul_count;
          state_next      = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RR;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_II;
        cmd.acc_op  = ACC_RE_LOAD;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RI;
        cmd.acc_op  = ACC_RE_SUB;
        state_next  = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_IR;
        cmd.acc_op  = ACC_IM_LOAD;
        state_next  = S_MUL4;
      end
      S_MUL4: begin
        cmd.acc_op = ACC_IM_ADD;
        state_next = S_WUPD;
      end
      S_WUPD: begin
        cmd.w_load    = 1'b1;
        mul_left_next = mul_left - CW'(1);
        state_next    = (mul_left == CW'(1)) ? S_ZUPD : S_MUL0;
      end
      S_ZUPD: begin
        cmd.z_update = 1'b1;
        state_next   = S_CHECK;
      end
      S_SEC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SECTOR;
        state_next    = S_SEC_W;
      end
      S_SEC_W: begin
        cmd.div_sel = DIV_SECTOR;
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          state_next    = S_RISE;
        end
      end
      S_RISE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RISE;
        state_next    = S_RISE_W;
      end
      S_RISE_W: begin
        cmd.div_sel = DIV_RISE;
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          state_next    = S_FALL;
        end
      end
      S_FALL: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FALL;
        state_next    = S_FALL_W;
      end
      S_FALL_W: begin
        cmd.div_sel = DIV_FALL;
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          state_next    = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_left  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mul_left  <= mul_left_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hw/rtl/mandelbrot_escape_colour.sv
// ----------------------------------------------------------------------------
// Multibrot escape-time colouring
// Iterates z = z^k + c from z = 0 for one point and returns count and colour.
// ----------------------------------------------------------------------------
// Usage:
// The input channel transfers one point c (signed fixed point, COORD_FRAC_BITS
// fraction bits) when in_valid and in_ready are both high. The output channel
// transfers one result (count, escaped flag, RGB) per point, in order.
// in_ready is high only while the engine is idle; one point is worked on at
// a time. A finished result sits in the output register, so the next point
// is taken while the receiver still holds off out_ready; the engine stalls
// only when a second result is ready before the first has been transferred.
// For exponent k, a round is a check state, k - 1 complex multiplies on one
// shared 32x32 multiplier and an update state; a point that escapes then
// runs three serial divisions for its colour. After loading the result the
// controller returns to idle and only then takes the next point.
// Configuration: index 0 is iteration_limit, index 1 is power; write only
// while idle. Synchronous reset restores limit 80 and power 2, empties the
// output register and returns the controller to idle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_colour import mec_pkg::*; #(
  parameter int COORD_FRAC_BITS = 28,
  parameter int MAX_POWER       = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]     cfg_data
);

  // Configuration registers; the user must write them only while the engine is idle; the block does not enforce it.
  logic [COUNT_W-1:0] iteration_limit;
  logic [POWER_W-1:0] power;

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= ITER_LIMIT_RESET;
      power           <= POWER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ITER_LIMIT: iteration_limit <= cfg_data;
        REG_POWER:      power           <= cfg_data[POWER_W-1:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences rounds and divisions; the datapath only acts
  // on the command bits it is given each cycle.
  mec_ctrl #(
    .MAX_POWER (MAX_POWER)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .power     (power),
    .status    (status),
    .cmd       (cmd)
  );

  mec_dpath #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_item         (in_data),
    .iteration_limit (iteration_limit),
    .result          (out_data)
  );

`ifndef SYNTH
  // A point that did not escape ran exactly up to the limit.
  a_inside_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.escaped |-> out_data.iter_count == iteration_limit)
    else $error("non-escaped result count differs from the limit");

  // A point that did not escape is coloured black.
  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.escaped |->
      out_data.red == '0 && out_data.green == '0 && out_data.blue == '0)
    else $error("non-escaped result is not black");

  // Every fully saturated hue has one channel at full scale.
  a_escaped_full_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.escaped |->
      out_data.red == 8'd255 || out_data.green == 8'd255 || out_data.blue == 8'd255)
    else $error("escaped colour has no full-scale channel");

  // An escaped count is always below the limit.
  a_escaped_below_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.escaped |-> out_data.iter_count < iteration_limit)
    else $error("escaped result count at or above the limit");
`endif

endmodule
